// ----- hw/rtl/tcm_pkg.sv -----
// ---------------------------------------------------------------------------
// Two-channel mixer package
// Operation codes, register indexes and fixed widths shared by the mixer.
// ---------------------------------------------------------------------------
package tcm_pkg;

   // Mix operation codes
   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_ADD_CTR  = 4'd1,
      OP_AVG      = 4'd2,
      OP_ABSDIFF  = 4'd3,
      OP_SUB      = 4'd4,
      OP_SUB_CTR  = 4'd5,
      OP_MUL      = 4'd6,
      OP_MUL_CTR  = 4'd7,
      OP_DIV      = 4'd8,
      OP_DIV_CTR  = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_AMIN     = 4'd12,
      OP_AMAX     = 4'd13,
      OP_CH1_ONLY = 4'd14,
      OP_INVALID  = 4'd15
   } mix_op_type;

   // Register indexes of the write port
   typedef enum logic [2:0] {
      CSR_MIX_OP       = 3'd0,
      CSR_FIRST_SCALE  = 3'd1,
      CSR_FIRST_OFFSET = 3'd2,
      CSR_SECOND_SCALE = 3'd3,
      CSR_SECOND_OFFS  = 3'd4,
      CSR_INVERT       = 3'd5,
      CSR_RESULT_LOW   = 3'd6,
      CSR_RESULT_HIGH  = 3'd7
   } csr_idx_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int SAMPLE_W    = 16;
   localparam int SCALE_W     = 11;
   localparam int OFFSET_W    = 12;
   localparam int RESULT_W    = 16;

   localparam int SCALE_RESET       = 100;
   localparam int RESULT_HIGH_RESET = 2047;
   localparam int INVALID_VALUE     = 1025;

   // Quotient bits kept by the mix divider; larger quotients saturate
   localparam int QSAT_BITS = 17;

   // Divide by 100 as shift by 2 then divide by 25 via reciprocal
   localparam int PCT_SHIFT   = 2;
   localparam int PCT_REST    = 25;
   localparam int DIV25_K     = 171798691;
   localparam int DIV25_KW    = 28;
   localparam int DIV25_SHIFT = 32;

endpackage

// ----- hw/rtl/tcm_div.sv -----
// ---------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division, one quotient bit per stage, truncating toward zero.
// Quotients beyond QB bits saturate in magnitude. Sideband rides along.
// ---------------------------------------------------------------------------
module tcm_div #(
   parameter int NUM_W  = 29,
   parameter int DEN_W  = 17,
   parameter int QB     = 11,
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [NUM_W-1:0] in_num,
   input  logic signed [DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [QB:0]      out_quot,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int NS    = QB + 1;
   localparam int CMP_W = NUM_W + DEN_W + QB;

   logic [NS-1:0]     vld_ff;
   logic [NS:0]       en;
   logic [NUM_W-1:0]  rem_ff  [NS];
   logic [DEN_W-1:0]  den_ff  [NS];
   logic [QB-1:0]     quo_ff  [NS];
   logic [SIDE_W-1:0] side_ff [NS];
   logic [NS-1:0]     neg_ff;
   logic [NS-1:0]     ovf_ff;

   logic             num_neg;
   logic             den_neg;
   logic [NUM_W-1:0] num_mag;
   logic [DEN_W-1:0] den_mag;
   logic             ovf_in;
   logic [QB-1:0]    qmag;

   // Stall chain: a stage moves when empty or when the next one moves
   always_comb begin
      en[NS] = out_ready;
      for (int i = NS - 1; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= in_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // Take magnitudes and flag quotients too large to hold
   assign num_neg = in_num[NUM_W-1];
   assign den_neg = in_den[DEN_W-1];
   assign num_mag = num_neg ? (~in_num + NUM_W'(1)) : in_num;
   assign den_mag = den_neg ? (~in_den + DEN_W'(1)) : in_den;
   assign ovf_in  = CMP_W'(num_mag) >= (CMP_W'(den_mag) << QB);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]  <= num_mag;
         den_ff[0]  <= den_mag;
         quo_ff[0]  <= '0;
         neg_ff[0]  <= num_neg ^ den_neg;
         ovf_ff[0]  <= ovf_in;
         side_ff[0] <= in_side;
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar g = 1; g < NS; g++) begin : g_step
      localparam int B = QB - g;
      logic [CMP_W-1:0] trial;
      logic [CMP_W-1:0] diff;
      logic             take;
      logic [QB-1:0]    qn;

      always_comb begin
         trial = CMP_W'(den_ff[g-1]) << B;
         diff  = CMP_W'(rem_ff[g-1]) - trial;
         take  = CMP_W'(rem_ff[g-1]) >= trial;
         qn    = quo_ff[g-1];
         qn[B] = take;
      end

      always_ff @(posedge clock) begin
         if (en[g]) begin
            rem_ff[g]  <= take ? diff[NUM_W-1:0] : rem_ff[g-1];
            den_ff[g]  <= den_ff[g-1];
            quo_ff[g]  <= qn;
            neg_ff[g]  <= neg_ff[g-1];
            ovf_ff[g]  <= ovf_ff[g-1];
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   // Saturate and restore the sign
   assign qmag      = ovf_ff[NS-1] ? '1 : quo_ff[NS-1];
   assign out_quot  = neg_ff[NS-1] ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
   assign out_side  = side_ff[NS-1];
   assign out_valid = vld_ff[NS-1];
   assign in_ready  = en[0];

endmodule

// ----- hw/rtl/two_channel_mixer_top.sv -----
// ---------------------------------------------------------------------------
// Two-channel mixer
// Normalises two source samples onto the native range, scales, offsets and
// optionally inverts them, combines them by the selected operation and
// clamps the result to the programmed bounds.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  req     | req_valid/req_ready | presence, sample and range of both sources
//  rsp     | rsp_valid/rsp_ready | rsp_mixed_value, rsp_failsafe
//  csr     | csr_write_en        | csr_index, csr_wdata, written at once
//
// One request per cycle is taken while rsp_ready keeps the pipeline moving. The
// channel dividers hold NATIVE_BITS + 1 stages, the mix divider 18 and nine
// further stages handle clamping, scaling and mixing.
// Reset clears every valid bit and loads the register defaults.
// A stalled response holds only the stages behind it that are full; empty
// stages keep filling, so nothing is lost or repeated.
// ---------------------------------------------------------------------------
module two_channel_mixer_top #(
   parameter int NATIVE_BITS = 11
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_first_present,
   input  logic signed [tcm_pkg::SAMPLE_W-1:0]   req_first_sample,
   input  logic signed [tcm_pkg::SAMPLE_W-1:0]   req_first_range_low,
   input  logic signed [tcm_pkg::SAMPLE_W-1:0]   req_first_range_high,
   input  logic                                  req_second_present,
   input  logic signed [tcm_pkg::SAMPLE_W-1:0]   req_second_sample,
   input  logic signed [tcm_pkg::SAMPLE_W-1:0]   req_second_range_low,
   input  logic signed [tcm_pkg::SAMPLE_W-1:0]   req_second_range_high,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [tcm_pkg::RESULT_W-1:0]   rsp_mixed_value,
   output logic                                  rsp_failsafe,
   input  logic                                  csr_write_en,
   input  logic [tcm_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [tcm_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import tcm_pkg::*;

   localparam int NB     = NATIVE_BITS;
   localparam int CW     = NB + 7;          // channel value after offset/invert
   localparam int RW     = 2 * CW + 4;      // pre-clamp mix result
   localparam int DW     = SAMPLE_W + 1;    // sample differences and spans
   localparam int CNUM_W = DW + NB + 1;     // mapping numerator
   localparam int PW     = NB + 12;         // percent product
   localparam int XW     = PW - PCT_SHIFT;  // magnitude after divide by 4
   localparam int TW     = XW + DIV25_KW;   // reciprocal product
   localparam int QW     = TW - DIV25_SHIFT;
   localparam int MP_W   = 2 * CW + 2;      // mix product
   localparam int MNUM_W = 2 * CW + 3;
   localparam int MDEN_W = CW + 1;

   localparam logic [NB-1:0]         NMAX_U  = {NB{1'b1}};
   localparam logic [NB-1:0]         HALF_U  = NMAX_U >> 1;
   localparam logic signed [DW-1:0]  NMAX_D  = DW'(2 ** NB - 1);
   localparam logic signed [CW-1:0]  NMAX_C  = CW'(2 ** NB - 1);
   localparam logic signed [CW:0]    NMID_C  = (CW + 1)'(2 ** (NB - 1));
   localparam logic signed [RW-1:0]  NMAX_R  = RW'(2 ** NB - 1);
   localparam logic signed [RW-1:0]  NMID_R  = RW'(2 ** (NB - 1));
   localparam logic signed [RW-1:0]  QTR_R   = RW'(2 ** (NB - 2));

   typedef struct packed {
      logic          fs;
      logic          native;
      logic          empty;
      logic [NB-1:0] vc;
   } lane_side_type;

   typedef struct packed {
      logic                 fs;
      logic                 use_div;
      logic                 add_mid;
      logic signed [RW-1:0] res;
   } mix_side_type;

   function automatic logic signed [CW+1:0] half_trunc(input logic signed [CW+1:0] d);
      logic signed [CW+1:0] t;
      t = d[CW+1] ? d + (CW + 2)'(1) : d;
      return t >>> 1;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   mix_op_type                   op_ff;
   logic signed [SCALE_W-1:0]    scale_ff [2];
   logic signed [OFFSET_W-1:0]   offs_ff  [2];
   logic [1:0]                   inv_ff;
   logic signed [RESULT_W-1:0]   rlow_ff;
   logic signed [RESULT_W-1:0]   rhigh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff       <= OP_ADD;
         scale_ff[0] <= SCALE_W'(SCALE_RESET);
         scale_ff[1] <= SCALE_W'(SCALE_RESET);
         offs_ff[0]  <= '0;
         offs_ff[1]  <= '0;
         inv_ff      <= '0;
         rlow_ff     <= '0;
         rhigh_ff    <= RESULT_W'(RESULT_HIGH_RESET);
      end else if (csr_write_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_MIX_OP:       op_ff       <= mix_op_type'(csr_wdata[3:0]);
            CSR_FIRST_SCALE:  scale_ff[0] <= csr_wdata[SCALE_W-1:0];
            CSR_FIRST_OFFSET: offs_ff[0]  <= csr_wdata[OFFSET_W-1:0];
            CSR_SECOND_SCALE: scale_ff[1] <= csr_wdata[SCALE_W-1:0];
            CSR_SECOND_OFFS:  offs_ff[1]  <= csr_wdata[OFFSET_W-1:0];
            CSR_INVERT:       inv_ff      <= csr_wdata[1:0];
            CSR_RESULT_LOW:   rlow_ff     <= csr_wdata[RESULT_W-1:0];
            CSR_RESULT_HIGH:  rhigh_ff    <= csr_wdata[RESULT_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Stage valids and the stall chain
   // ------------------------------------------------------------------
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff, vg_ff, vh_ff, vi_ff;
   logic en_a, en_b, en_c, en_d, en_e, en_f, en_g, en_h, en_i;
   logic [1:0] cdiv_in_ready;
   logic [1:0] cdiv_out_valid;
   logic       mdiv_in_ready;
   logic       mdiv_out_valid;

   assign en_i = !vi_ff || rsp_ready;
   assign en_h = !vh_ff || mdiv_in_ready;
   assign en_g = !vg_ff || en_h;
   assign en_f = !vf_ff || en_g;
   assign en_e = !ve_ff || en_f;
   assign en_d = !vd_ff || en_e;
   assign en_c = !vc_ff || en_d;
   assign en_b = !vb_ff || cdiv_in_ready[0];
   assign en_a = !va_ff || en_b;
   assign req_ready = en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
         vi_ff <= 1'b0;
      end else begin
         if (en_a) va_ff <= req_valid;
         if (en_b) vb_ff <= va_ff;
         if (en_c) vc_ff <= cdiv_out_valid[0];
         if (en_d) vd_ff <= vc_ff;
         if (en_e) ve_ff <= vd_ff;
         if (en_f) vf_ff <= ve_ff;
         if (en_g) vg_ff <= vf_ff;
         if (en_h) vh_ff <= vg_ff;
         if (en_i) vi_ff <= mdiv_out_valid;
      end
   end

   // ------------------------------------------------------------------
   // Per-channel datapath
   // ------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] smp [2];
   logic signed [SAMPLE_W-1:0] rlo [2];
   logic signed [SAMPLE_W-1:0] rhi [2];

   assign smp[0] = req_first_sample;
   assign rlo[0] = req_first_range_low;
   assign rhi[0] = req_first_range_high;
   assign smp[1] = req_second_sample;
   assign rlo[1] = req_second_range_low;
   assign rhi[1] = req_second_range_high;

   logic fs_in;
   assign fs_in = !req_first_present || (op_ff != OP_CH1_ONLY && !req_second_present);

   logic signed [DW-1:0]     a_dn_ff   [2];
   logic signed [DW-1:0]     a_span_ff [2];
   lane_side_type            a_side_ff [2];
   logic signed [CNUM_W-1:0] b_num_ff  [2];
   logic signed [DW-1:0]     b_span_ff [2];
   lane_side_type            b_side_ff [2];
   logic signed [NB:0]       cdiv_quot [2];
   lane_side_type            cdiv_side [2];
   logic signed [PW-1:0]     c_prod_ff [2];
   logic [XW-1:0]            d_x_ff    [2];
   logic [TW-1:0]            d_t_ff    [2];
   logic [1:0]               d_neg_ff;
   logic [QW-1:0]            e_q_ff    [2];
   logic [1:0]               e_neg_ff;
   logic signed [CW-1:0]     f_val_ff  [2];
   logic c_fs_ff, d_fs_ff, e_fs_ff, f_fs_ff;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [SAMPLE_W-1:0] vcl;
      lane_side_type              side_in;
      logic [NB-1:0]              mv;
      logic [PW-1:0]              mag;
      logic [XW-1:0]              rest;
      logic [QW-1:0]              q_in;
      logic signed [CW-1:0]       qs;
      logic signed [CW-1:0]       sv;
      logic signed [CW-1:0]       ov;

      // Clamp to the source range and form the mapping terms
      always_comb begin
         if (smp[l] < rlo[l]) begin
            vcl = rlo[l];
         end else if (smp[l] > rhi[l]) begin
            vcl = rhi[l];
         end else begin
            vcl = smp[l];
         end
         side_in.fs     = fs_in;
         side_in.native = (rlo[l] == '0) && (DW'(rhi[l]) == NMAX_D);
         side_in.empty  = (rlo[l] == rhi[l]);
         side_in.vc     = vcl[NB-1:0];
      end

      always_ff @(posedge clock) begin
         if (en_a) begin
            a_dn_ff[l]   <= DW'(vcl) - DW'(rlo[l]);
            a_span_ff[l] <= DW'(rhi[l]) - DW'(rlo[l]);
            a_side_ff[l] <= side_in;
         end
      end

      // Scale the offset into the native range
      always_ff @(posedge clock) begin
         if (en_b) begin
            b_num_ff[l]  <= CNUM_W'(a_dn_ff[l]) * CNUM_W'(NMAX_D);
            b_span_ff[l] <= a_span_ff[l];
            b_side_ff[l] <= a_side_ff[l];
         end
      end

      tcm_div #(
         .NUM_W  (CNUM_W),
         .DEN_W  (DW),
         .QB     (NB),
         .SIDE_W ($bits(lane_side_type))
      ) u_map_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vb_ff),
         .in_ready  (cdiv_in_ready[l]),
         .in_num    (b_num_ff[l]),
         .in_den    (b_span_ff[l]),
         .in_side   (b_side_ff[l]),
         .out_valid (cdiv_out_valid[l]),
         .out_ready (en_c),
         .out_quot  (cdiv_quot[l]),
         .out_side  (cdiv_side[l])
      );

      // Pick the mapped value and apply the percent gain
      always_comb begin
         if (cdiv_side[l].native) begin
            mv = cdiv_side[l].vc;
         end else if (cdiv_side[l].empty) begin
            mv = HALF_U;
         end else begin
            mv = cdiv_quot[l][NB-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en_c) begin
            c_prod_ff[l] <= PW'(signed'({1'b0, mv})) * PW'(scale_ff[l]);
         end
      end

      // Divide the magnitude by 100: drop two bits, then reciprocal of 25
      assign mag = c_prod_ff[l][PW-1] ? PW'(-c_prod_ff[l]) : PW'(c_prod_ff[l]);

      always_ff @(posedge clock) begin
         if (en_d) begin
            d_x_ff[l]   <= mag[PW-1:PCT_SHIFT];
            d_t_ff[l]   <= TW'(mag[PW-1:PCT_SHIFT]) * TW'(DIV25_K);
            d_neg_ff[l] <= c_prod_ff[l][PW-1];
         end
      end

      // Correct the estimate, which is at most one short
      assign rest = d_x_ff[l]
                    - XW'(d_t_ff[l][DIV25_SHIFT +: QW]) * XW'(PCT_REST);
      assign q_in = d_t_ff[l][DIV25_SHIFT +: QW] + QW'(rest >= XW'(PCT_REST));

      always_ff @(posedge clock) begin
         if (en_e) begin
            e_q_ff[l]   <= q_in;
            e_neg_ff[l] <= d_neg_ff[l];
         end
      end

      // Restore the sign, add the offset and invert if asked
      assign qs = signed'(CW'(e_q_ff[l]));
      assign sv = e_neg_ff[l] ? -qs : qs;
      assign ov = sv + CW'(offs_ff[l]);

      always_ff @(posedge clock) begin
         if (en_f) begin
            f_val_ff[l] <= inv_ff[l] ? (NMAX_C - ov) : ov;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) c_fs_ff <= cdiv_side[0].fs | cdiv_side[1].fs;
      if (en_d) d_fs_ff <= c_fs_ff;
      if (en_e) e_fs_ff <= d_fs_ff;
      if (en_f) f_fs_ff <= e_fs_ff;
   end

   // ------------------------------------------------------------------
   // Mix stage G: simple operations and the shared multiplier
   // ------------------------------------------------------------------
   logic signed [CW:0]     ca;
   logic signed [CW:0]     cb;
   logic signed [RW-1:0]   ae, be, cae, cbe, tmp, avg_s, abs_ca, abs_cb;
   logic signed [RW-1:0]   simple_in;
   logic signed [CW:0]     mx, my;
   logic signed [MP_W-1:0] g_prod_ff;
   logic signed [CW-1:0]   g_b_ff;
   logic signed [CW:0]     g_ca_ff;
   logic signed [CW:0]     g_cb_ff;
   logic signed [RW-1:0]   g_simple_ff;
   logic                   g_fs_ff;

   assign ca = (CW + 1)'(f_val_ff[0]) - NMID_C;
   assign cb = (CW + 1)'(f_val_ff[1]) - NMID_C;

   always_comb begin
      ae     = RW'(f_val_ff[0]);
      be     = RW'(f_val_ff[1]);
      cae    = RW'(ca);
      cbe    = RW'(cb);
      abs_ca = cae[RW-1] ? -cae : cae;
      abs_cb = cbe[RW-1] ? -cbe : cbe;
      tmp    = ae + be + RW'(1);
      avg_s  = tmp[RW-1] ? tmp + RW'(1) : tmp;
      mx     = cb;
      my     = ca;
      unique case (op_ff)
         OP_ADD:      simple_in = ae + be;
         OP_ADD_CTR:  simple_in = cae + cbe + NMID_R;
         OP_AVG:      simple_in = avg_s >>> 1;
         OP_ABSDIFF:  simple_in = (ae < be) ? be - ae : ae - be;
         OP_SUB:      simple_in = ae - be;
         OP_SUB_CTR:  simple_in = cae - cbe + NMID_R;
         OP_MIN:      simple_in = (ae < be) ? ae : be;
         OP_MAX:      simple_in = (ae > be) ? ae : be;
         OP_AMIN:     simple_in = (abs_ca <= abs_cb) ? ae : be;
         OP_AMAX:     simple_in = (abs_ca >= abs_cb) ? ae : be;
         OP_CH1_ONLY: simple_in = ae;
         OP_INVALID:  simple_in = RW'(INVALID_VALUE);
         OP_MUL: begin
            simple_in = '0;
            mx        = (CW + 1)'(f_val_ff[0]);
            my        = (CW + 1)'(f_val_ff[1]);
         end
         OP_DIV: begin
            simple_in = '0;
            mx        = (CW + 1)'(f_val_ff[0]);
            my        = (CW + 1)'(NMAX_C);
         end
         OP_MUL_CTR,
         OP_DIV_CTR:  simple_in = '0;
         default:     simple_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_g) begin
         g_prod_ff   <= MP_W'(mx) * MP_W'(my);
         g_b_ff      <= f_val_ff[1];
         g_ca_ff     <= ca;
         g_cb_ff     <= cb;
         g_simple_ff <= simple_in;
         g_fs_ff     <= f_fs_ff;
      end
   end

   // ------------------------------------------------------------------
   // Mix stage H: round products, set up the divider
   // ------------------------------------------------------------------
   logic signed [RW-1:0]     pe, pr;
   logic signed [CW+1:0]     db;
   logic signed [MNUM_W-1:0] num_in;
   logic signed [MDEN_W-1:0] den_in;
   mix_side_type             hside_in;
   logic signed [MNUM_W-1:0] h_num_ff;
   logic signed [MDEN_W-1:0] h_den_ff;
   mix_side_type             h_side_ff;

   always_comb begin
      pe               = RW'(g_prod_ff);
      pr               = pe + (g_prod_ff[MP_W-1] ? -QTR_R : QTR_R);
      db               = (CW + 2)'(g_b_ff);
      num_in           = '0;
      den_in           = '0;
      hside_in.fs      = g_fs_ff;
      hside_in.use_div = 1'b0;
      hside_in.add_mid = 1'b0;
      hside_in.res     = g_simple_ff;
      unique case (op_ff)
         OP_MUL:     hside_in.res = (pe + NMID_R) >>> NB;
         OP_MUL_CTR: hside_in.res = (pr >>> (NB - 1)) + NMID_R;
         OP_DIV: begin
            num_in           = MNUM_W'(g_prod_ff) + MNUM_W'(half_trunc(db));
            den_in           = MDEN_W'(g_b_ff);
            hside_in.use_div = (g_b_ff != '0);
            hside_in.res     = NMAX_R;
         end
         OP_DIV_CTR: begin
            num_in = (MNUM_W'(g_ca_ff) <<< (NB - 1))
                     + MNUM_W'(half_trunc((CW + 2)'(g_cb_ff)));
            den_in           = g_cb_ff;
            hside_in.use_div = (g_cb_ff != '0);
            hside_in.add_mid = 1'b1;
            hside_in.res     = g_ca_ff[CW] ? '0 : NMAX_R;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en_h) begin
         h_num_ff  <= num_in;
         h_den_ff  <= den_in;
         h_side_ff <= hside_in;
      end
   end

   logic signed [QSAT_BITS:0] mdiv_quot;
   mix_side_type              mdiv_side;

   tcm_div #(
      .NUM_W  (MNUM_W),
      .DEN_W  (MDEN_W),
      .QB     (QSAT_BITS),
      .SIDE_W ($bits(mix_side_type))
   ) u_mix_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vh_ff),
      .in_ready  (mdiv_in_ready),
      .in_num    (h_num_ff),
      .in_den    (h_den_ff),
      .in_side   (h_side_ff),
      .out_valid (mdiv_out_valid),
      .out_ready (en_i),
      .out_quot  (mdiv_quot),
      .out_side  (mdiv_side)
   );

   // ------------------------------------------------------------------
   // Output stage: pick the result and clamp it
   // ------------------------------------------------------------------
   logic signed [RW-1:0]       res_sel, lo_r, hi_r, res_cl;
   logic signed [RESULT_W-1:0] mixed_ff;
   logic                       fs_ff;

   always_comb begin
      lo_r = RW'(rlow_ff);
      hi_r = RW'(rhigh_ff);
      if (mdiv_side.use_div) begin
         res_sel = RW'(mdiv_quot) + (mdiv_side.add_mid ? NMID_R : '0);
      end else begin
         res_sel = mdiv_side.res;
      end
      if (res_sel < lo_r) begin
         res_cl = lo_r;
      end else if (res_sel > hi_r) begin
         res_cl = hi_r;
      end else begin
         res_cl = res_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (en_i) begin
         mixed_ff <= mdiv_side.fs ? '0 : res_cl[RESULT_W-1:0];
         fs_ff    <= mdiv_side.fs;
      end
   end

   assign rsp_valid       = vi_ff;
   assign rsp_mixed_value = mixed_ff;
   assign rsp_failsafe    = fs_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (cdiv_in_ready[0] == cdiv_in_ready[1]) && (cdiv_out_valid[0] == cdiv_out_valid[1]))
      else $error("channel dividers out of step");

   a_failsafe_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failsafe |-> rsp_mixed_value == '0)
      else $error("failsafe response carries a value");

   a_within_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_failsafe && (rlow_ff <= rhigh_ff)
      |-> (rsp_mixed_value >= rlow_ff) && (rsp_mixed_value <= rhigh_ff))
      else $error("response outside result bounds");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule
